// File: rtl/kes_pkg.sv
// ---------------------------------------------------------------------------
// Kepler solver package
// Shared widths, constants, state codes and output formatting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kes_pkg;

	// Internal values are signed Q30 carried in 40 bits
	localparam int W  = 40;
	localparam int MW = 35;          // multiplier operand width
	localparam int CW = 34;          // CORDIC x/y width
	localparam int CORDIC_N = 30;
	localparam int SQ_W = 62;
	localparam int DR_W = W + 9;     // divider remainder width

	localparam int ITERATION_CAP = 16;
	localparam int CNT_W = $clog2(ITERATION_CAP + 1);

	typedef logic signed [W-1:0]  val_t;
	typedef logic signed [MW-1:0] mop_t;
	typedef logic signed [CW-1:0] cval_t;

	localparam val_t Q_ONE     = 40'sd1073741824;
	localparam val_t Q_PI      = 40'sd3373259426;
	localparam val_t Q_TWO_PI  = 40'sd6746518852;
	localparam val_t Q_HALF_PI = 40'sd1686629713;
	localparam val_t E_LIMIT   = 40'sd17179869184;
	localparam val_t LIM_TWO   = 40'sd2147483648;
	localparam val_t LIM_WIDE  = 40'sd274877906944;
	localparam val_t Q824_MAX  = 40'sd2147483647;
	localparam val_t Q824_MIN  = -40'sd2147483648;
	localparam cval_t Q_CORDIC_GAIN = 34'sd652032874;
	localparam mop_t Q_C085    = 35'sd912680550;
	localparam mop_t Q_SIXTH   = 35'sd178956971;

	localparam logic [29:0] ATAN_TAB [CORDIC_N] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2};

	localparam logic CFG_TOLERANCE  = 1'b0;
	localparam logic CFG_ITER_LIMIT = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SC0, ST_E0, ST_SC, ST_EC, ST_NUM, ST_DIV1, ST_DEN1, ST_DIV2,
		ST_T1, ST_T2, ST_T3, ST_DEN2, ST_DIV3, ST_FSC, ST_FRAD, ST_FD0, ST_FVX,
		ST_FSQ, ST_FPY, ST_FVY, ST_FVYW, ST_OUT
	} kes_state_t;

	// Q30 -> Q8.24 with rounding and saturation
	function automatic logic signed [31:0] to_q824(input val_t v);
		val_t t;
		t = (v + val_t'(32)) >>> 6;
		if (t > Q824_MAX)
			t = Q824_MAX;
		else if (t < Q824_MIN)
			t = Q824_MIN;
		return t[31:0];
	endfunction

endpackage

// File: rtl/kes_cordic.sv
// ---------------------------------------------------------------------------
// Kepler solver sin/cos unit
// Range reduction one step a cycle, then a 30-step rotation CORDIC.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kes_cordic (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  kes_pkg::val_t ang,
	output logic          busy,
	output kes_pkg::cval_t sin_o,
	output kes_pkg::cval_t cos_o
);
	import kes_pkg::*;

	logic busy_q, red_q, flip_q;
	val_t r_q;
	cval_t x_q, y_q;
	logic [4:0] i_q;
	val_t at;

	assign at = val_t'({1'b0, ATAN_TAB[i_q]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			red_q  <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			red_q  <= 1'b1;
		end else if (busy_q && red_q) begin
			if (r_q <= Q_PI && r_q >= -Q_PI)
				red_q <= 1'b0;
		end else if (busy_q && i_q == 5'(CORDIC_N - 1)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q    <= ang;
			x_q    <= Q_CORDIC_GAIN;
			y_q    <= '0;
			flip_q <= 1'b0;
			i_q    <= '0;
		end else if (busy_q && red_q) begin
			if (r_q > Q_PI)
				r_q <= r_q - Q_TWO_PI;
			else if (r_q < -Q_PI)
				r_q <= r_q + Q_TWO_PI;
			else if (r_q > Q_HALF_PI) begin
				r_q    <= Q_PI - r_q;
				flip_q <= 1'b1;
			end else if (r_q < -Q_HALF_PI) begin
				r_q    <= -Q_PI - r_q;
				flip_q <= 1'b1;
			end
		end else if (busy_q) begin
			if (!r_q[W-1]) begin
				x_q <= x_q - (y_q >>> i_q);
				y_q <= y_q + (x_q >>> i_q);
				r_q <= r_q - at;
			end else begin
				x_q <= x_q + (y_q >>> i_q);
				y_q <= y_q - (x_q >>> i_q);
				r_q <= r_q + at;
			end
			i_q <= i_q + 5'd1;
		end
	end

	assign busy  = busy_q;
	assign sin_o = y_q;
	assign cos_o = flip_q ? -x_q : x_q;

endmodule

// File: rtl/kes_div.sv
// ---------------------------------------------------------------------------
// Kepler solver divider
// Signed Q30 quotient, restoring, one bit a cycle, saturating at +-2 or +-256.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kes_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  kes_pkg::val_t num,
	input  kes_pkg::val_t den,
	input  logic          wide,
	output logic          busy,
	output kes_pkg::val_t quot
);
	import kes_pkg::*;

	localparam logic [5:0] STEPS_WIDE = 6'd38;
	localparam logic [5:0] STEPS_TWO  = 6'd31;

	logic busy_q, neg_q;
	logic [DR_W-1:0] r_q, dd_q, r2, dshift, n_ext;
	logic [W-1:0] acc_q, acc_nxt, n_abs, d_abs;
	logic [5:0] cnt_q;
	logic ge;
	val_t lim, quot_q;

	assign n_abs  = num[W-1] ? -num : num;
	assign d_abs  = den[W-1] ? -den : den;
	assign n_ext  = DR_W'(n_abs);
	assign dshift = wide ? (DR_W'(d_abs) << 8) : (DR_W'(d_abs) << 1);
	assign lim    = wide ? LIM_WIDE : LIM_TWO;
	assign r2     = {r_q[DR_W-2:0], 1'b0};
	assign ge     = r2 >= dd_q;
	assign acc_nxt = {acc_q[W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (start)
			busy_q <= (den != '0) && (n_ext < dshift);
		else if (busy_q && cnt_q == 6'd1)
			busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[W-1] ^ den[W-1];
			r_q   <= n_ext;
			dd_q  <= dshift;
			acc_q <= '0;
			cnt_q <= wide ? STEPS_WIDE : STEPS_TWO;
			if (den == '0)
				quot_q <= (num == '0) ? '0 : (num[W-1] ? -lim : lim);
			else if (n_ext >= dshift)
				quot_q <= (num[W-1] ^ den[W-1]) ? -lim : lim;
		end else if (busy_q) begin
			r_q   <= ge ? r2 - dd_q : r2;
			acc_q <= acc_nxt;
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1)
				quot_q <= neg_q ? -val_t'(acc_nxt) : val_t'(acc_nxt);
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

// File: rtl/kes_sqrt.sv
// ---------------------------------------------------------------------------
// Kepler solver square root
// Digit-by-digit integer root of rad * 2^30, one result bit a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kes_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] rad,
	output logic        busy,
	output logic [30:0] root
);
	import kes_pkg::*;

	logic busy_q;
	logic [SQ_W-1:0] v_q, res_q, bitv, trial;
	logic [4:0] k_q;

	assign bitv  = SQ_W'(1) << {k_q, 1'b0};
	assign trial = res_q + bitv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (start)
			busy_q <= 1'b1;
		else if (busy_q && k_q == '0)
			busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= SQ_W'({rad, 30'd0});
			res_q <= '0;
			k_q   <= 5'd30;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bitv;
			end else begin
				res_q <= res_q >> 1;
			end
			k_q <= k_q - 5'd1;
		end
	end

	assign busy = busy_q;
	assign root = res_q[30:0];

endmodule

// File: rtl/kepler_equation_solver.sv
// ---------------------------------------------------------------------------
// Kepler equation solver
// Danby iteration for E - e sin E = M, then unit-orbit position and velocity.
// ---------------------------------------------------------------------------
// One item at a time. The input is stalled from the transfer until the result
// is loaded into the output register. Each correction round holds one CORDIC
// pass (more range-reduction steps for larger E), three divides and a handful
// of shared-multiplier steps. Setup and the final position/velocity pass (two
// wide divides) come on top, and an item runs 1 to iteration_limit rounds.
// A divide that saturates at once ends early. The CORDIC and the bit-serial
// divider set the time an item takes; one multiplier is shared.
`timescale 1ns / 1ps

module kepler_equation_solver (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] anomaly,
	input  logic [29:0]        eccentricity,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic               converged,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);
	import kes_pkg::*;

	kes_state_t st_q, nxt;

	logic [15:0] tol_q;
	logic [4:0]  lim_q;
	logic [CNT_W-1:0] cnt_q, rounds_q;
	logic [29:0] e_q;
	logic conv_q, out_valid_q;
	val_t m_q, E_q, es_q, ec_q, num_q, d0_q, d2_q, tmp_q, vx_q, py_q, q_q;
	val_t m_in, e0, e_new, e_sum, d3_abs, ev, sv, cv;
	logic hit;

	logic cord_start, cord_busy, div_start, div_busy, div_wide, sqrt_start, sqrt_busy;
	val_t cord_ang, div_num, div_den, div_quot;
	cval_t s_w, c_w;
	logic [30:0] sqrt_rad, root;
	mop_t mul_a, mul_b;
	logic signed [2*MW-1:0] prod;

	assign m_in = val_t'(anomaly) <<< 2;
	assign ev   = val_t'({10'd0, e_q});
	assign sv   = val_t'(s_w);
	assign cv   = val_t'(c_w);
	assign e0   = s_w[CW-1] ? m_q - q_q : m_q + q_q;
	assign e_sum = E_q + div_quot;
	assign e_new = (e_sum > E_LIMIT) ? E_LIMIT : ((e_sum < -E_LIMIT) ? -E_LIMIT : e_sum);
	assign d3_abs = div_quot[W-1] ? -div_quot : div_quot;
	assign hit   = d3_abs < val_t'({tol_q, 2'b00});

	kes_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .ang(cord_ang),
		.busy(cord_busy), .sin_o(s_w), .cos_o(c_w)
	);

	kes_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .wide(div_wide), .busy(div_busy), .quot(div_quot)
	);

	kes_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .rad(sqrt_rad),
		.busy(sqrt_busy), .root(root)
	);

	// shared multiplier, Q30 rounding folded into the product register
	assign prod = mul_a * mul_b;
	always_ff @(posedge clk) begin
		q_q <= val_t'((prod + (2*MW)'(1 << 29)) >>> 30);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			tol_q       <= 16'd268;
			lim_q       <= 5'd8;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= nxt;
			if (cfg_we) begin
				case (cfg_index)
					CFG_TOLERANCE:  tol_q <= cfg_data;
					CFG_ITER_LIMIT: lim_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (st_q == ST_OUT && !(out_valid_q && out_stall))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		nxt        = st_q;
		cord_start = 1'b0;
		cord_ang   = E_q;
		div_start  = 1'b0;
		div_num    = num_q;
		div_den    = d0_q;
		div_wide   = 1'b0;
		sqrt_start = 1'b0;
		sqrt_rad   = '0;
		mul_a      = '0;
		mul_b      = '0;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					cord_start = 1'b1;
					cord_ang   = m_in;
					nxt        = ST_SC0;
				end
			end
			ST_SC0: begin
				mul_a = mop_t'({5'd0, e_q});
				mul_b = Q_C085;
				if (!cord_busy)
					nxt = ST_E0;
			end
			ST_E0: begin
				cord_start = 1'b1;
				cord_ang   = e0;
				nxt        = ST_SC;
			end
			ST_SC: begin
				mul_a = mop_t'({5'd0, e_q});
				mul_b = mop_t'(s_w);
				if (!cord_busy)
					nxt = ST_EC;
			end
			ST_EC: begin
				mul_a = mop_t'({5'd0, e_q});
				mul_b = mop_t'(c_w);
				nxt   = ST_NUM;
			end
			ST_NUM: begin
				div_start = 1'b1;
				div_num   = m_q - E_q + es_q;
				div_den   = Q_ONE - q_q;
				nxt       = ST_DIV1;
			end
			ST_DIV1: begin
				mul_a = div_quot[MW-1:0];
				mul_b = es_q[MW-1:0];
				if (!div_busy)
					nxt = ST_DEN1;
			end
			ST_DEN1: begin
				div_start = 1'b1;
				div_den   = d0_q + (q_q >>> 1);
				nxt       = ST_DIV2;
			end
			ST_DIV2: begin
				mul_a = div_quot[MW-1:0];
				mul_b = div_quot[MW-1:0];
				if (!div_busy)
					nxt = ST_T1;
			end
			ST_T1: begin
				mul_a = q_q[MW-1:0];
				mul_b = ec_q[MW-1:0];
				nxt   = ST_T2;
			end
			ST_T2: begin
				mul_a = q_q[MW-1:0];
				mul_b = Q_SIXTH;
				nxt   = ST_T3;
			end
			ST_T3: begin
				mul_a = d2_q[MW-1:0];
				mul_b = es_q[MW-1:0];
				nxt   = ST_DEN2;
			end
			ST_DEN2: begin
				div_start = 1'b1;
				div_den   = d0_q + (q_q >>> 1) + tmp_q;
				nxt       = ST_DIV3;
			end
			ST_DIV3: begin
				if (!div_busy) begin
					cord_start = 1'b1;
					cord_ang   = e_new;
					nxt = (hit || CNT_W'(cnt_q + 1'b1) == rounds_q) ? ST_FSC : ST_SC;
				end
			end
			ST_FSC: begin
				mul_a = mop_t'({5'd0, e_q});
				mul_b = mop_t'({5'd0, e_q});
				if (!cord_busy)
					nxt = ST_FRAD;
			end
			ST_FRAD: begin
				sqrt_start = 1'b1;
				sqrt_rad   = (q_q > Q_ONE) ? '0 : 31'(Q_ONE - q_q);
				mul_a = mop_t'({5'd0, e_q});
				mul_b = mop_t'(c_w);
				nxt   = ST_FD0;
			end
			ST_FD0: begin
				div_start = 1'b1;
				div_num   = -sv;
				div_den   = Q_ONE - q_q;
				div_wide  = 1'b1;
				nxt       = ST_FVX;
			end
			ST_FVX: begin
				if (!div_busy)
					nxt = ST_FSQ;
			end
			ST_FSQ: begin
				mul_a = mop_t'({4'd0, root});
				mul_b = mop_t'(s_w);
				if (!sqrt_busy)
					nxt = ST_FPY;
			end
			ST_FPY: begin
				mul_a = mop_t'({4'd0, root});
				mul_b = mop_t'(c_w);
				nxt   = ST_FVY;
			end
			ST_FVY: begin
				div_start = 1'b1;
				div_num   = q_q;
				div_wide  = 1'b1;
				nxt       = ST_FVYW;
			end
			ST_FVYW: begin
				if (!div_busy)
					nxt = ST_OUT;
			end
			ST_OUT: begin
				if (!(out_valid_q && out_stall))
					nxt = ST_IDLE;
			end
			default: nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				m_q    <= m_in;
				e_q    <= eccentricity;
				cnt_q  <= '0;
				conv_q <= 1'b0;
				if (lim_q == '0)
					rounds_q <= CNT_W'(1);
				else if (int'(lim_q) > ITERATION_CAP)
					rounds_q <= CNT_W'(ITERATION_CAP);
				else
					rounds_q <= CNT_W'(lim_q);
			end
			ST_E0:  E_q <= e0;
			ST_EC:  es_q <= q_q;
			ST_NUM: begin
				ec_q  <= q_q;
				d0_q  <= Q_ONE - q_q;
				num_q <= m_q - E_q + es_q;
			end
			ST_DIV2: d2_q <= div_quot;
			ST_T3:   tmp_q <= q_q;
			ST_DIV3: begin
				if (!div_busy) begin
					E_q   <= e_new;
					cnt_q <= CNT_W'(cnt_q + 1'b1);
					if (hit)
						conv_q <= 1'b1;
				end
			end
			ST_FD0: d0_q <= Q_ONE - q_q;
			ST_FVX: vx_q <= div_quot;
			ST_FPY: py_q <= q_q;
			ST_OUT: begin
				if (!(out_valid_q && out_stall)) begin
					pos_x     <= to_q824(cv - ev);
					pos_y     <= to_q824(py_q);
					vel_x     <= to_q824(vx_q);
					vel_y     <= to_q824(div_quot);
					converged <= conv_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (st_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: rtl/kes_check.sv
// ---------------------------------------------------------------------------
// Kepler solver port checker
// Watches the top-level ports and is bound to the solver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kes_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] pos_x,
	input logic               converged
);

	// a transfer in occupies the solver and stalls the input
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while solving");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(converged))
		else $error("stalled result changed");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(pos_x) && !$isunknown(converged))
		else $error("result has unknown bits");

endmodule

bind kepler_equation_solver kes_check u_kes_check (.*);

// File: tb/sv/kepler_equation_solver_tb.sv
// ---------------------------------------------------------------------------
// Kepler equation solver testbench
// Drives anomaly/eccentricity pairs through the valid/stall ports and checks
// every result against an in-bench fixed-point Danby solver, while
// configuration is swept between phases and both sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kepler_equation_solver_tb;
	import kes_pkg::*;

	typedef struct {
		logic signed [31:0] px, py, vx, vy;
		logic               conv;
	} orbit_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [31:0] anomaly = '0;
	logic [29:0]        eccentricity = '0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
	logic               converged;
	logic               cfg_we = 0;
	logic               cfg_index = 0;
	logic [15:0]        cfg_data = '0;

	kepler_equation_solver dut (.*);

	initial forever #4 clk = ~clk;

	// solver settings as the block should hold them
	int unsigned tol_reg = 268;
	int unsigned iter_reg = 8;

	orbit_t pending_orbits[$];
	int errors = 0;
	int n_sent = 0, n_checked = 0, n_conv = 0;
	bit sender_busy_only = 0;   // no sender idling when set
	bit recv_quiet = 0;         // no receiver idling when set
	int hold_cycles = 0;

	// ---------------- predictor ----------------
	function automatic longint q_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint q_div(longint num, longint den, longint lim_int);
		longint lim;
		bit neg;
		longint unsigned n, d, qi, r, frac;
		longint q;
		lim = lim_int <<< 30;
		neg = (num < 0) != (den < 0);
		frac = 0;
		if (den == 0) begin
			if (num == 0)
				return 0;
			return num > 0 ? lim : -lim;
		end
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		qi = n / d;
		if (qi >= lim_int)
			return neg ? -lim : lim;
		r = n % d;
		for (int i = 0; i < 30; i++) begin
			r = r << 1;
			frac = frac << 1;
			if (r >= d) begin
				r = r - d;
				frac = frac | 1;
			end
		end
		q = longint'((qi << 30) | frac);
		return neg ? -q : q;
	endfunction

	task automatic rotate_angle(input longint ang, output longint s, output longint c);
		longint r, x, y, nx;
		bit flip;
		r = ang;
		x = longint'(Q_CORDIC_GAIN);
		y = 0;
		flip = 0;
		while (r > longint'(Q_PI))
			r -= longint'(Q_TWO_PI);
		while (r < -longint'(Q_PI))
			r += longint'(Q_TWO_PI);
		if (r > longint'(Q_HALF_PI)) begin
			r = longint'(Q_PI) - r;
			flip = 1;
		end else if (r < -longint'(Q_HALF_PI)) begin
			r = -longint'(Q_PI) - r;
			flip = 1;
		end
		for (int i = 0; i < 30; i++) begin
			if (r >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				r -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				r += longint'(ATAN_TAB[i]);
			end
			x = nx;
		end
		s = y;
		c = flip ? -x : x;
	endtask

	function automatic longint int_root(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else
				res = res >> 1;
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	function automatic logic signed [31:0] q824(longint v);
		longint r;
		r = (v + 32) >>> 6;
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		return r[31:0];
	endfunction

	task automatic solve_orbit(input logic signed [31:0] ma, input logic [29:0] ecc,
			output orbit_t o);
		longint m, e, ea, s, c, es, ec, num, d0, d1, d2, d3, den, tol, rad, sq, lim;
		int rounds;
		m = longint'(ma) * 4;
		e = longint'(ecc);
		tol = longint'(tol_reg) * 4;
		lim = longint'(E_LIMIT);
		rounds = iter_reg;
		o.conv = 0;
		if (rounds < 1)
			rounds = 1;
		if (rounds > ITERATION_CAP)
			rounds = ITERATION_CAP;
		rotate_angle(m, s, c);
		ea = (s >= 0) ? m + q_mul(e, longint'(Q_C085)) : m - q_mul(e, longint'(Q_C085));
		for (int i = 0; i < rounds; i++) begin
			rotate_angle(ea, s, c);
			es = q_mul(e, s);
			ec = q_mul(e, c);
			num = -(ea - es - m);
			d0 = longint'(Q_ONE) - ec;
			d1 = q_div(num, d0, 2);
			den = d0 + (q_mul(d1, es) >>> 1);
			d2 = q_div(num, den, 2);
			den = d0 + (q_mul(d2, es) >>> 1)
				+ q_mul(q_mul(q_mul(d2, d2), ec), longint'(Q_SIXTH));
			d3 = q_div(num, den, 2);
			ea += d3;
			if (ea > lim)
				ea = lim;
			if (ea < -lim)
				ea = -lim;
			if ((d3 < 0 ? -d3 : d3) < tol) begin
				o.conv = 1;
				break;
			end
		end
		rotate_angle(ea, s, c);
		rad = longint'(Q_ONE) - q_mul(e, e);
		if (rad < 0)
			rad = 0;
		sq = int_root(longint'(rad) << 30);
		d0 = longint'(Q_ONE) - q_mul(e, c);
		o.px = q824(c - e);
		o.py = q824(q_mul(sq, s));
		o.vx = q824(q_div(-s, d0, 256));
		o.vy = q824(q_div(q_mul(sq, c), d0, 256));
	endtask

	// ---------------- drivers ----------------
	task automatic send_orbit(input logic signed [31:0] ma, input logic [29:0] ecc);
		orbit_t o;
		bit done;
		in_valid = 1;
		anomaly = ma;
		eccentricity = ecc;
		done = 0;
		while (!done) begin
			@(posedge clk);
			done = !in_stall;
			@(negedge clk);
		end
		solve_orbit(ma, ecc, o);
		pending_orbits.push_back(o);
		n_sent++;
		if (!sender_busy_only && $urandom_range(99) < 31) begin
			in_valid = 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid = 0;
		while (pending_orbits.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		wait_idle();
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		if (idx == CFG_TOLERANCE)
			tol_reg = val;
		else
			iter_reg = val[4:0];
	endtask

	function automatic logic [29:0] rand_ecc();
		case ($urandom_range(3))
			0: return 30'($urandom);
			1: return 30'($urandom_range(32'h0100_0000));
			2: return 30'(30'h3FFF_FFFF - $urandom_range(32'h0010_0000));
			default: return 30'($urandom_range(32'h3000_0000));
		endcase
	endfunction

	function automatic logic signed [31:0] rand_anomaly();
		// mostly within +-3.5 rad, sometimes anywhere
		if ($urandom_range(3) == 0)
			return $urandom;
		return $signed($urandom_range(32'h7000_0000)) - 32'sh3800_0000;
	endfunction

	// receiver side
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1;
		end else
			out_stall <= !recv_quiet && ($urandom_range(99) < 31);
	end

	always @(posedge clk) begin
		orbit_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_orbits.size() == 0) begin
				$error("result with nothing pending");
				errors++;
			end else begin
				x = pending_orbits.pop_front();
				n_checked++;
				n_conv += x.conv;
				if (pos_x !== x.px) begin
					$error("pos_x exp %0d got %0d", x.px, pos_x); errors++;
				end
				if (pos_y !== x.py) begin
					$error("pos_y exp %0d got %0d", x.py, pos_y); errors++;
				end
				if (vel_x !== x.vx) begin
					$error("vel_x exp %0d got %0d", x.vx, vel_x); errors++;
				end
				if (vel_y !== x.vy) begin
					$error("vel_y exp %0d got %0d", x.vy, vel_y); errors++;
				end
				if (converged !== x.conv) begin
					$error("converged exp %0d got %0d", x.conv, converged); errors++;
				end
			end
		end
	end

	// ---------------- tests ----------------
	task automatic test_directed();
		send_orbit(0, 0);
		send_orbit(32'sh7FFF_FFFF, 0);
		send_orbit(-32'sh8000_0000, 0);
		send_orbit(0, 30'h3FFF_FFFF);
		send_orbit(32'sh7FFF_FFFF, 30'h3FFF_FFFF);
		send_orbit(-32'sh8000_0000, 30'h3FFF_FFFF);
		send_orbit(32'sh3243_F6A9, 30'h2000_0000);   // near pi
		send_orbit(-32'sh3243_F6A9, 30'h2000_0000);
		send_orbit(-32'sh1000_0000, 30'h1000_0000);  // sin(M) < 0 start
		send_orbit(32'sh1000_0000, 30'h1000_0000);
		send_orbit(1, 30'h3FFF_FFF0);                 // e near one, tiny divisor
		send_orbit(-1, 30'h3FFF_FFF0);
		send_orbit(32'sh1921_FB54, 30'h3FFF_FFFF);   // near pi/2
		send_orbit(32'sh5555_5555, 30'h2AAA_AAAA);
		send_orbit(-32'sh2AAA_AAAB, 30'h1555_5555);
	endtask

	task automatic test_settings();
		logic [15:0] tols[4] = '{16'd0, 16'd1, 16'd65535, 16'd268};
		logic [15:0] iters[5] = '{16'd0, 16'd1, 16'd16, 16'd31, 16'd3};
		foreach (tols[i]) begin
			write_reg(CFG_TOLERANCE, tols[i]);
			foreach (iters[j]) begin
				write_reg(CFG_ITER_LIMIT, iters[j]);
				repeat (4) send_orbit(rand_anomaly(), rand_ecc());
			end
		end
	endtask

	task automatic test_random();
		write_reg(CFG_TOLERANCE, 16'd268);
		write_reg(CFG_ITER_LIMIT, 16'd5);
		for (int i = 0; i < 1500; i++) begin
			sender_busy_only = (i >= 600 && i < 800);
			recv_quiet = sender_busy_only;
			send_orbit(rand_anomaly(), rand_ecc());
		end
		sender_busy_only = 0;
		recv_quiet = 0;
		write_reg(CFG_TOLERANCE, 16'($urandom_range(1, 65535)));
		write_reg(CFG_ITER_LIMIT, 16'($urandom_range(1, 16)));
		repeat (150) send_orbit(rand_anomaly(), rand_ecc());
	endtask

	task automatic test_backpressure();
		write_reg(CFG_ITER_LIMIT, 16'd2);
		hold_cycles = 4000;
		sender_busy_only = 1;
		repeat (12) send_orbit(rand_anomaly(), rand_ecc());
		sender_busy_only = 0;
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_settings();
		test_random();
		wait_idle();
		repeat (50) @(negedge clk);
		$display("sent %0d orbits, checked %0d results, %0d converged", n_sent,
			n_checked, n_conv);
		$display("covered tolerance/limit extremes, near-unit eccentricity, backpressure");
		if (errors == 0)
			$display("kepler_equation_solver_tb: PASS");
		else
			$display("kepler_equation_solver_tb: FAIL");
		$finish;
	end

	initial begin
		#400_000_000;
		$display("kepler_equation_solver_tb: FAIL");
		$finish;
	end

endmodule
